// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the vector magnitude block.
// Each macro expects i_clk and i_rst_n to exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// File: hw/rtl/v3m_pkg.sv
// Package for the vector magnitude block: result width and stage control type.
// Used by v3m_square and vector3_magnitude; depends on nothing.
`default_nettype none

package v3m_pkg;

    localparam int LEN_WIDTH = 32;

    typedef struct packed {
        logic load_pp;
        logic load_sq;
    } t_sq_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/v3m_square.sv
// Two-stage squarer for one signed component: magnitude and split products, then sum.
// Depends on v3m_pkg for the stage control type.
`default_nettype none

module v3m_square
    import v3m_pkg::*;
#(
    parameter int COMP_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire t_sq_ctl                     i_ctl,
    input  wire logic [COMP_WIDTH-1:0]       i_comp,
    output logic      [2*COMP_WIDTH-1:0]     o_square
);

    localparam int LO_W = (COMP_WIDTH + 1) / 2;
    localparam int HI_W = COMP_WIDTH - LO_W;
    localparam int SQ_W = 2 * COMP_WIDTH;

    logic [COMP_WIDTH-1:0]  w_mag;
    logic [2*HI_W-1:0]      n_hh;
    logic [HI_W+LO_W-1:0]   n_hl;
    logic [2*LO_W-1:0]      n_ll;
    logic [2*HI_W-1:0]      r_hh;
    logic [HI_W+LO_W-1:0]   r_hl;
    logic [2*LO_W-1:0]      r_ll;
    logic [SQ_W-1:0]        n_square;
    logic [SQ_W-1:0]        r_square;

    assign w_mag = i_comp[COMP_WIDTH-1] ? (~i_comp + {{(COMP_WIDTH-1){1'b0}}, 1'b1}) : i_comp;

    always_comb begin
        n_hh = {{HI_W{1'b0}}, w_mag[COMP_WIDTH-1:LO_W]}
             * {{HI_W{1'b0}}, w_mag[COMP_WIDTH-1:LO_W]};
        n_hl = {{LO_W{1'b0}}, w_mag[COMP_WIDTH-1:LO_W]}
             * {{HI_W{1'b0}}, w_mag[LO_W-1:0]};
        n_ll = {{LO_W{1'b0}}, w_mag[LO_W-1:0]}
             * {{LO_W{1'b0}}, w_mag[LO_W-1:0]};
    end

    always_comb begin
        n_square = ({{(SQ_W-2*HI_W){1'b0}}, r_hh} << (2 * LO_W))
                 + ({{(SQ_W-HI_W-LO_W){1'b0}}, r_hl} << (LO_W + 1))
                 + {{(SQ_W-2*LO_W){1'b0}}, r_ll};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_pp) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_ll <= n_ll;
        end
        if (i_ctl.load_sq) begin
            r_square <= n_square;
        end
    end

    assign o_square = r_square;

endmodule

`default_nettype wire

// File: hw/rtl/v3m_sqrt_cell.sv
// One cell of the square root chain: settles one root bit from two radicand bits.
// Registered stage with its own valid and ready; no package dependency.
`default_nettype none

module v3m_sqrt_cell #(
    parameter int ROOT_W = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [2*ROOT_W-1:0]     i_rad,
    input  wire logic [ROOT_W+1:0]       i_rem,
    input  wire logic [ROOT_W-1:0]       i_root,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic      [2*ROOT_W-1:0]     o_rad,
    output logic      [ROOT_W+1:0]       o_rem,
    output logic      [ROOT_W-1:0]       o_root
);

    localparam int RAD_W = 2 * ROOT_W;

    logic [ROOT_W+3:0]  w_cand;
    logic [ROOT_W+3:0]  w_trial;
    logic [ROOT_W+3:0]  w_diff;
    logic               w_ge;
    logic               r_valid;
    logic [RAD_W-1:0]   r_rad;
    logic [ROOT_W+1:0]  r_rem;
    logic [ROOT_W-1:0]  r_root;

    assign w_cand  = {i_rem, i_rad[RAD_W-1:RAD_W-2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_ge    = (w_cand >= w_trial);
    assign w_diff  = w_cand - w_trial;
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[ROOT_W+1:0] : w_cand[ROOT_W+1:0];
            r_root <= {i_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

`default_nettype wire

// File: hw/rtl/vector3_magnitude.sv
// Top level of the vector magnitude block: squarers, sum stage and square root chain.
// Depends on v3m_pkg, v3m_square, v3m_sqrt_cell and assert_macros.svh.
//
//   channel  direction  handshake           payload
//   request  in         i_valid / o_ready   i_comp_x, i_comp_y, i_comp_z
//   result   out        o_valid / i_ready   o_length
//
// One request is taken per cycle while o_ready is high, and each passes through three squaring
// and summing stages and then one root cell per root bit.
// Every stage stalls on its own, so bubbles close up while the output waits.
// Reset clears only the stage valid bits.
`default_nettype none
`include "assert_macros.svh"

module vector3_magnitude
    import v3m_pkg::*;
#(
    parameter int COMP_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [COMP_WIDTH-1:0]  i_comp_x,
    input  wire logic [COMP_WIDTH-1:0]  i_comp_y,
    input  wire logic [COMP_WIDTH-1:0]  i_comp_z,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [LEN_WIDTH-1:0]   o_length
);

    localparam int SQ_W = 2 * COMP_WIDTH;

    t_sq_ctl            w_ctl;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               w_rdy1;
    logic               w_rdy2;
    logic               w_rdy3;
    logic [SQ_W-1:0]    w_sq_x;
    logic [SQ_W-1:0]    w_sq_y;
    logic [SQ_W-1:0]    w_sq_z;
    logic [SQ_W-1:0]    r_sum;

    logic                    c_valid [0:COMP_WIDTH];
    logic                    c_ready [0:COMP_WIDTH];
    logic [SQ_W-1:0]         c_rad   [0:COMP_WIDTH];
    logic [COMP_WIDTH+1:0]   c_rem   [0:COMP_WIDTH];
    logic [COMP_WIDTH-1:0]   c_root  [0:COMP_WIDTH];

    assign w_rdy3  = !r_v3 || c_ready[0];
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_ctl.load_pp = i_valid && w_rdy1;
    assign w_ctl.load_sq = r_v1 && w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    v3m_square #(.COMP_WIDTH(COMP_WIDTH)) u_sq_x (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_comp   (i_comp_x),
        .o_square (w_sq_x)
    );

    v3m_square #(.COMP_WIDTH(COMP_WIDTH)) u_sq_y (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_comp   (i_comp_y),
        .o_square (w_sq_y)
    );

    v3m_square #(.COMP_WIDTH(COMP_WIDTH)) u_sq_z (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_comp   (i_comp_z),
        .o_square (w_sq_z)
    );

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_rdy3) begin
            r_sum <= w_sq_x + w_sq_y + w_sq_z;
        end
    end

    assign c_valid[0] = r_v3;
    assign c_rad[0]   = r_sum;
    assign c_rem[0]   = '0;
    assign c_root[0]  = '0;

    for (genvar g = 0; g < COMP_WIDTH; g++) begin : g_cell
        v3m_sqrt_cell #(.ROOT_W(COMP_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_rad   (c_rad[g]),
            .i_rem   (c_rem[g]),
            .i_root  (c_root[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_rad   (c_rad[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_root  (c_root[g+1])
        );
    end

    assign c_ready[COMP_WIDTH] = i_ready;
    assign o_valid             = c_valid[COMP_WIDTH];

    if (COMP_WIDTH > LEN_WIDTH) begin : g_sat
        assign o_length = (|c_root[COMP_WIDTH][COMP_WIDTH-1:LEN_WIDTH]) ? '1
                        : c_root[COMP_WIDTH][LEN_WIDTH-1:0];
    end else if (COMP_WIDTH == LEN_WIDTH) begin : g_same
        assign o_length = c_root[COMP_WIDTH];
    end else begin : g_ext
        assign o_length = {{(LEN_WIDTH-COMP_WIDTH){1'b0}}, c_root[COMP_WIDTH]};
    end

    `ASSERT_NEVER(a_ready_only_when_full, !o_ready && !(r_v1 && r_v2 && r_v3), "front stalled with a free stage")
    `ASSERT_CLK(a_sum_held, r_v3 && !c_ready[0] |=> r_v3 && $stable(r_sum), "sum lost while chain stalled")
    `ASSERT_CLK(a_sq_stage_held, r_v2 && !w_rdy3 |=> r_v2, "square stage dropped a request")

endmodule

`default_nettype wire
